/* sv/mtp_pkg.sv */
`default_nettype none
package mtp_pkg;

  localparam int unsigned ChW          = 8;
  localparam int unsigned CountW       = 5;
  localparam int unsigned NibW         = 4;
  localparam int unsigned DigitCntW    = 2;
  localparam int unsigned MaxAddrBytes = 16;

  localparam logic [CountW-1:0] MAX_ADDR_BYTES  = CountW'(MaxAddrBytes);
  localparam logic [CountW-1:0] RESET_MAX_BYTES = CountW'(6);

  localparam logic [ChW-1:0] CH_NUL   = 8'h00;
  localparam logic [ChW-1:0] CH_COLON = 8'h3A;
  localparam logic [ChW-1:0] CH_0     = 8'h30;
  localparam logic [ChW-1:0] CH_9     = 8'h39;
  localparam logic [ChW-1:0] CH_UA    = 8'h41;
  localparam logic [ChW-1:0] CH_UF    = 8'h46;
  localparam logic [ChW-1:0] CH_LA    = 8'h61;
  localparam logic [ChW-1:0] CH_LF    = 8'h66;
  localparam logic [ChW-1:0] HEX_TEN  = 8'd10;

  localparam logic [DigitCntW-1:0] DIGITS_NONE = 2'd0;
  localparam logic [DigitCntW-1:0] DIGITS_ONE  = 2'd1;
  localparam logic [DigitCntW-1:0] DIGITS_TWO  = 2'd2;

  typedef struct packed {
    logic            is_hex;
    logic            is_colon;
    logic [NibW-1:0] nibble;
  } char_class_t;

  typedef struct packed {
    logic [ChW-1:0]    data_byte;
    logic              has_byte;
    logic              done_res;
    logic              failed;
    logic [CountW-1:0] byte_count;
  } result_t;

  function automatic char_class_t classify(input logic [ChW-1:0] c);
    char_class_t    r;
    logic [ChW-1:0] diff;
    r    = '0;
    diff = '0;
    if (c >= CH_0 && c <= CH_9) begin
      diff     = c - CH_0;
      r.is_hex = 1'b1;
    end else if (c >= CH_UA && c <= CH_UF) begin
      diff     = c - CH_UA + HEX_TEN;
      r.is_hex = 1'b1;
    end else if (c >= CH_LA && c <= CH_LF) begin
      diff     = c - CH_LA + HEX_TEN;
      r.is_hex = 1'b1;
    end else if (c == CH_COLON) begin
      r.is_colon = 1'b1;
    end
    r.nibble = diff[NibW-1:0];
    return r;
  endfunction

endpackage
`default_nettype wire

/* sv/mtp_parser.sv */
`default_nettype none
module mtp_parser (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         step_i,
  input  wire logic [mtp_pkg::ChW-1:0]      ch_i,
  input  wire logic [mtp_pkg::CountW-1:0]   max_bytes_i,
  output logic                              res_valid_o,
  output mtp_pkg::result_t                  res_o
);

  logic [mtp_pkg::DigitCntW-1:0] digit_cnt_q, digit_cnt_d;
  logic [mtp_pkg::NibW-1:0]      first_nib_q, first_nib_d;
  logic [mtp_pkg::NibW-1:0]      second_nib_q, second_nib_d;
  logic [mtp_pkg::CountW-1:0]    bytes_done_q, bytes_done_d;
  logic                          discard_q, discard_d;

  logic [mtp_pkg::CountW-1:0]    limit;
  logic [mtp_pkg::ChW-1:0]       field_val;
  mtp_pkg::char_class_t          cls;

  always_comb begin
    limit = (max_bytes_i > mtp_pkg::MAX_ADDR_BYTES) ? mtp_pkg::MAX_ADDR_BYTES : max_bytes_i;
    cls   = mtp_pkg::classify(ch_i);
    if (digit_cnt_q == mtp_pkg::DIGITS_TWO) begin
      field_val = {first_nib_q, second_nib_q};
    end else if (digit_cnt_q == mtp_pkg::DIGITS_ONE) begin
      field_val = {{(mtp_pkg::ChW-mtp_pkg::NibW){1'b0}}, first_nib_q};
    end else begin
      field_val = '0;
    end
  end

  always_comb begin
    digit_cnt_d  = digit_cnt_q;
    first_nib_d  = first_nib_q;
    second_nib_d = second_nib_q;
    bytes_done_d = bytes_done_q;
    discard_d    = discard_q;
    res_valid_o  = 1'b0;
    res_o        = '0;
    if (step_i) begin
      if (discard_q) begin
        if (ch_i == mtp_pkg::CH_NUL) begin
          digit_cnt_d  = '0;
          first_nib_d  = '0;
          second_nib_d = '0;
          bytes_done_d = '0;
          discard_d    = 1'b0;
        end
      end else if (bytes_done_q >= limit) begin
        res_valid_o      = 1'b1;
        res_o.done_res   = 1'b1;
        res_o.failed     = 1'b1;
        res_o.byte_count = bytes_done_q;
        digit_cnt_d      = '0;
        first_nib_d      = '0;
        second_nib_d     = '0;
        bytes_done_d     = '0;
        discard_d        = (ch_i != mtp_pkg::CH_NUL);
      end else if (ch_i == mtp_pkg::CH_NUL) begin
        res_valid_o      = 1'b1;
        res_o.data_byte  = field_val;
        res_o.has_byte   = 1'b1;
        res_o.done_res   = 1'b1;
        res_o.byte_count = bytes_done_q + mtp_pkg::CountW'(1);
        digit_cnt_d      = '0;
        first_nib_d      = '0;
        second_nib_d     = '0;
        bytes_done_d     = '0;
      end else if ((!cls.is_hex && !cls.is_colon) ||
                   (cls.is_hex && digit_cnt_q >= mtp_pkg::DIGITS_TWO)) begin
        res_valid_o      = 1'b1;
        res_o.done_res   = 1'b1;
        res_o.failed     = 1'b1;
        res_o.byte_count = bytes_done_q;
        digit_cnt_d      = '0;
        first_nib_d      = '0;
        second_nib_d     = '0;
        bytes_done_d     = '0;
        discard_d        = 1'b1;
      end else if (cls.is_colon) begin
        res_valid_o      = 1'b1;
        res_o.data_byte  = field_val;
        res_o.has_byte   = 1'b1;
        res_o.byte_count = bytes_done_q + mtp_pkg::CountW'(1);
        bytes_done_d     = bytes_done_q + mtp_pkg::CountW'(1);
        digit_cnt_d      = '0;
        first_nib_d      = '0;
        second_nib_d     = '0;
      end else begin
        if (digit_cnt_q == mtp_pkg::DIGITS_NONE) begin
          first_nib_d = cls.nibble;
        end else begin
          second_nib_d = cls.nibble;
        end
        digit_cnt_d = digit_cnt_q + mtp_pkg::DigitCntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      digit_cnt_q  <= '0;
      first_nib_q  <= '0;
      second_nib_q <= '0;
      bytes_done_q <= '0;
      discard_q    <= 1'b0;
    end else begin
      digit_cnt_q  <= digit_cnt_d;
      first_nib_q  <= first_nib_d;
      second_nib_q <= second_nib_d;
      bytes_done_q <= bytes_done_d;
      discard_q    <= discard_d;
    end
  end

endmodule
`default_nettype wire

/* sv/mac_text_parser_unit.sv */
// Parses colon-separated hex address text (e.g. "0a:1B::f") arriving one character per
// slave transaction; a zero character ends the string. Each closed field yields one master
// transaction with the byte and the running byte count; the terminator or a failure sets
// tlast, and a failure (bad character, third digit in a field, more fields than max_bytes,
// capped at 16) also sets tuser[1], after which characters are dropped up to the terminator.
// Digits produce no output. One character is accepted every cycle, and the only stall is
// master-side backpressure; a character passes the input register, then the parse step into
// the output register. max_bytes resets to 6 and may be written only while idle.
`default_nettype none
module mac_text_parser_unit (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       s_axis_tvalid,
  output logic                            s_axis_tready,
  input  wire logic [7:0]                 s_axis_tdata,   // [7:0] ch
  output logic                            m_axis_tvalid,
  input  wire logic                       m_axis_tready,
  output logic [15:0]                     m_axis_tdata,   // [7:0] data_byte, [12:8] byte_count
  output logic                            m_axis_tlast,   // done_res
  output logic [1:0]                      m_axis_tuser,   // [0] has_byte, [1] failed
  input  wire logic                       cfg_valid_i,
  output logic                            cfg_ready_o,
  input  wire logic [mtp_pkg::CountW-1:0] cfg_data_i
);

  logic [mtp_pkg::CountW-1:0] max_bytes_q;
  logic                       in_vld_q;
  logic [mtp_pkg::ChW-1:0]    ch_q;
  logic                       out_vld_q, out_vld_d;
  mtp_pkg::result_t           out_q;
  logic                       out_free;
  logic                       step;
  logic                       res_valid;
  mtp_pkg::result_t           res;

  assign cfg_ready_o   = 1'b1;
  assign out_free      = !out_vld_q || m_axis_tready;
  assign step          = in_vld_q && out_free;
  assign s_axis_tready = !in_vld_q || out_free;

  mtp_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .ch_i        (ch_q),
    .max_bytes_i (max_bytes_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  always_comb begin
    out_vld_d = out_vld_q;
    if (out_free) begin
      out_vld_d = step && res_valid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_bytes_q <= mtp_pkg::RESET_MAX_BYTES;
      in_vld_q    <= 1'b0;
      out_vld_q   <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        max_bytes_q <= cfg_data_i;
      end
      if (s_axis_tready) begin
        in_vld_q <= s_axis_tvalid;
      end
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      ch_q <= s_axis_tdata;
    end
    if (step && res_valid) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {3'b000, out_q.byte_count, out_q.data_byte};
  assign m_axis_tlast  = out_q.done_res;
  assign m_axis_tuser  = {out_q.failed, out_q.has_byte};

endmodule
`default_nettype wire

/* sv/mtp_checker.sv */
`default_nettype none
module mtp_checker (
  input wire logic                       clk_i,
  input wire logic                       rst_ni,
  input wire logic                       s_axis_tvalid,
  input wire logic                       s_axis_tready,
  input wire logic [7:0]                 s_axis_tdata,
  input wire logic                       m_axis_tvalid,
  input wire logic                       m_axis_tready,
  input wire logic [15:0]                m_axis_tdata,
  input wire logic                       m_axis_tlast,
  input wire logic [1:0]                 m_axis_tuser,
  input wire logic                       cfg_valid_i,
  input wire logic                       cfg_ready_o,
  input wire logic [mtp_pkg::CountW-1:0] cfg_data_i
);

  logic unused_in;
  assign unused_in = s_axis_tvalid ^ s_axis_tready ^ (^s_axis_tdata) ^
                     cfg_valid_i ^ cfg_ready_o ^ (^cfg_data_i);

  a_byte_xor_fail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(m_axis_tuser[0] && m_axis_tuser[1]))
    else $error("result carries a byte and a failure at once");

  a_fail_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser[1]) |-> m_axis_tlast)
    else $error("failure result does not end the string");

  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser[0]) |-> (m_axis_tdata[7:0] == 8'h00))
    else $error("byte field not zero without a byte");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[12:8] <= 5'd16 && m_axis_tdata[15:13] == 3'b000))
    else $error("byte count out of range");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
    else $error("stalled result changed");

endmodule

bind mac_text_parser_unit mtp_checker u_mtp_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast),
  .m_axis_tuser  (m_axis_tuser),
  .cfg_valid_i   (cfg_valid_i),
  .cfg_ready_o   (cfg_ready_o),
  .cfg_data_i    (cfg_data_i)
);
`default_nettype wire
